// File: hdl/tpag_pkg.sv
`timescale 1ns / 1ps
// Shared constants, types and helpers for the tensor permute address generator.
// Depends on nothing; used by tensor_permute_address_gen, tpag_result_checker and the testbench top.
package tpag_pkg;

  localparam int MAX_ORDER    = 4;
  localparam int VALUE_W      = 32;
  localparam int INDEX_W      = 32;
  localparam int ORDER_W      = 3;
  localparam int SIZE_W       = 9;
  localparam int COORD_W      = 8;
  localparam int AXIS_W       = 2;
  localparam int PERM_W       = 8;
  localparam int STRIDE_W     = 25;
  localparam int CFG_IDX_W    = 3;
  localparam int CFG_DATA_W   = 9;
  localparam int SETTLE_W     = 3;

  // Cycles the derived stride registers need after reset or a register write.
  localparam logic [SETTLE_W-1:0] SETTLE_CYCLES = 3'd5;

  localparam logic [ORDER_W-1:0] ORDER_MAX   = 3'd4;
  localparam logic [SIZE_W-1:0]  SIZE_MAX    = 9'd256;
  localparam logic [PERM_W-1:0]  PERM_RESET  = 8'd27;

  typedef enum logic [CFG_IDX_W-1:0] {
    REG_TENSOR_ORDER = 3'd0,
    REG_AXIS_SIZE_0  = 3'd1,
    REG_AXIS_SIZE_1  = 3'd2,
    REG_AXIS_SIZE_2  = 3'd3,
    REG_AXIS_SIZE_3  = 3'd4,
    REG_AXIS_PERM    = 3'd5,
    REG_USE_GIVEN    = 3'd6
  } cfg_reg_t;

  typedef logic [SIZE_W-1:0]   size_t;
  typedef logic [COORD_W-1:0]  coord_t;
  typedef logic [AXIS_W-1:0]   axis_t;
  typedef logic [STRIDE_W-1:0] stride_t;

  // Clamp a raw axis size into 1..256.
  function automatic size_t eff_size(input size_t raw);
    size_t s;
    s = raw;
    if (raw == '0) begin
      s = 9'd1;
    end else if (raw > SIZE_MAX) begin
      s = SIZE_MAX;
    end
    return s;
  endfunction

endpackage

// File: hdl/tensor_permute_address_gen.sv
`timescale 1ns / 1ps
// Top level of the tensor axis-permutation address generator.
// Depends on tpag_pkg for constants, types and the size clamp helper.
//
// Usage: source tensor elements arrive in row-major order on the in_ stream
// (in_tdata carries the element value). For every accepted item one result
// item leaves on the out_ stream: out_tdata holds the destination row-major
// index in the transposed tensor and the value, out_tlast marks the final
// element of the tensor and out_tuser flags an invalid permutation (the index
// is then 0). Axis sizes, order and permutation are written through the cfg_
// port while the block is idle.
// An accepted item is registered in the first stage, then in the output
// register, where out_tvalid rises; throughput is one item per cycle while
// the receiver keeps up and the strides are not settling. The index is a
// sum of four coordinate-times-stride products: the products are registered
// in the first stage and summed in the second.
// Strides are derived from the configuration by a short register pipeline;
// after reset and after every register write, in_tready stays low while
// those registers settle.
// Reset clears the coordinate odometer, loads the default configuration and
// empties the pipeline. When the receiver stalls, the output register holds its
// item and the first stage fills; in_tready then drops until space frees up.
module tensor_permute_address_gen (
  input  logic        clk,
  input  logic        rst_n,
  // Input stream.
  input  logic        in_tvalid,
  output logic        in_tready,
  input  logic [31:0] in_tdata,   // [31:0] element_value
  // Result stream.
  output logic        out_tvalid,
  input  logic        out_tready,
  output logic [63:0] out_tdata,  // [31:0] dest_index, [63:32] out_value
  output logic        out_tlast,  // last_element
  output logic        out_tuser,  // perm_error
  // Configuration write port.
  input  logic        cfg_we,
  input  logic [2:0]  cfg_index,
  input  logic [8:0]  cfg_wdata
);

  localparam int N = tpag_pkg::MAX_ORDER;

  // Configuration registers, raw as written.
  logic [tpag_pkg::ORDER_W-1:0] order_cfg_r;
  tpag_pkg::size_t              size_cfg_r [N];
  logic [tpag_pkg::PERM_W-1:0]  perm_cfg_r;
  logic                         use_cfg_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      order_cfg_r <= '0;
      for (int k = 0; k < N; k++) begin
        size_cfg_r[k] <= 9'd1;
      end
      perm_cfg_r <= tpag_pkg::PERM_RESET;
      use_cfg_r  <= 1'b0;
    end else if (cfg_we) begin
      unique case (cfg_index)
        tpag_pkg::REG_TENSOR_ORDER: order_cfg_r   <= cfg_wdata[tpag_pkg::ORDER_W-1:0];
        tpag_pkg::REG_AXIS_SIZE_0:  size_cfg_r[0] <= cfg_wdata;
        tpag_pkg::REG_AXIS_SIZE_1:  size_cfg_r[1] <= cfg_wdata;
        tpag_pkg::REG_AXIS_SIZE_2:  size_cfg_r[2] <= cfg_wdata;
        tpag_pkg::REG_AXIS_SIZE_3:  size_cfg_r[3] <= cfg_wdata;
        tpag_pkg::REG_AXIS_PERM:    perm_cfg_r    <= cfg_wdata[tpag_pkg::PERM_W-1:0];
        tpag_pkg::REG_USE_GIVEN:    use_cfg_r     <= cfg_wdata[0];
        default: ;
      endcase
    end
  end

  // Settle counter: items are held off while the derived registers catch up.
  logic [tpag_pkg::SETTLE_W-1:0] settle_r;
  logic [tpag_pkg::SETTLE_W-1:0] settle_nxt;

  always_comb begin
    settle_nxt = settle_r;
    if (cfg_we) begin
      settle_nxt = tpag_pkg::SETTLE_CYCLES;
    end else if (settle_r != '0) begin
      settle_nxt = settle_r - 3'd1;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      settle_r <= tpag_pkg::SETTLE_CYCLES;
    end else begin
      settle_r <= settle_nxt;
    end
  end

  // Derived stage 1: effective order, sizes, permutation, its validity, and
  // the size of the source axis behind each result axis.
  logic [tpag_pkg::ORDER_W-1:0] ord_nxt, ord_r;
  tpag_pkg::size_t              sz_nxt [N];
  tpag_pkg::size_t              sz_r   [N];
  tpag_pkg::axis_t              prm_nxt [N];
  tpag_pkg::size_t              f_nxt  [N];
  tpag_pkg::size_t              f_r    [N];
  tpag_pkg::axis_t              prm_r  [N];
  logic                         err_nxt, err_r;

  always_comb begin
    logic [tpag_pkg::ORDER_W-1:0] rev;
    ord_nxt = (order_cfg_r > tpag_pkg::ORDER_MAX) ? tpag_pkg::ORDER_MAX : order_cfg_r;
    err_nxt = 1'b0;
    for (int k = 0; k < N; k++) begin
      sz_nxt[k] = tpag_pkg::eff_size(size_cfg_r[k]);
    end
    for (int i = 0; i < N; i++) begin
      rev = ord_nxt - 3'(i) - 3'd1;
      prm_nxt[i] = use_cfg_r ? perm_cfg_r[2*i +: 2] : rev[tpag_pkg::AXIS_W-1:0];
    end
    // A result axis in use must name a source axis in use, each only once.
    for (int i = 0; i < N; i++) begin
      if (3'(i) < ord_nxt && {1'b0, prm_nxt[i]} >= ord_nxt) begin
        err_nxt = 1'b1;
      end
      for (int j = i + 1; j < N; j++) begin
        if (3'(j) < ord_nxt && prm_nxt[i] == prm_nxt[j]) begin
          err_nxt = 1'b1;
        end
      end
    end
    for (int i = 0; i < N; i++) begin
      f_nxt[i] = (3'(i) < ord_nxt) ? sz_nxt[prm_nxt[i]] : 9'd1;
    end
  end

  always_ff @(posedge clk) begin
    ord_r <= ord_nxt;
    err_r <= err_nxt;
    for (int k = 0; k < N; k++) begin
      sz_r[k]  <= sz_nxt[k];
      f_r[k]   <= f_nxt[k];
      prm_r[k] <= prm_nxt[k];
    end
  end

  // Derived stages 2 and 3: suffix products give each result axis its stride.
  logic [17:0]           sr1_r;
  tpag_pkg::size_t       sr2_r;
  logic [26:0]           sr0_full;
  tpag_pkg::stride_t     sr0_r;
  tpag_pkg::stride_t     sr [N];

  assign sr0_full = 27'(sr1_r) * 27'(f_r[1]);

  always_ff @(posedge clk) begin
    sr2_r <= f_r[3];
    sr1_r <= 18'(f_r[3]) * 18'(f_r[2]);
    sr0_r <= sr0_full[tpag_pkg::STRIDE_W-1:0];
  end

  always_comb begin
    sr[3] = 25'd1;
    sr[2] = 25'(sr2_r);
    sr[1] = 25'(sr1_r);
    sr[0] = sr0_r;
  end

  // Derived stage 4: move each stride to the source axis that it belongs to.
  tpag_pkg::stride_t stride_nxt [N];
  tpag_pkg::stride_t stride_r   [N];

  always_comb begin
    for (int j = 0; j < N; j++) begin
      stride_nxt[j] = '0;
      for (int i = 0; i < N; i++) begin
        if (3'(i) < ord_r && prm_r[i] == 2'(j)) begin
          stride_nxt[j] = stride_nxt[j] | sr[i];
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    for (int j = 0; j < N; j++) begin
      stride_r[j] <= stride_nxt[j];
    end
  end

  // Pipeline handshake.
  logic s1_v_r, s2_v_r;
  logic s2_ready, s1_move, s1_ready, in_acc;

  assign s2_ready  = !s2_v_r || out_tready;
  assign s1_move   = s1_v_r && s2_ready;
  assign s1_ready  = !s1_v_r || s1_move;
  assign in_tready = s1_ready && (settle_r == '0);
  assign in_acc    = in_tvalid && in_tready;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_v_r <= 1'b0;
      s2_v_r <= 1'b0;
    end else begin
      if (s1_ready) begin
        s1_v_r <= in_acc;
      end
      if (s2_ready) begin
        s2_v_r <= s1_move;
      end
    end
  end

  // Source coordinate odometer, last axis fastest. An axis moves only when
  // every faster axis wraps; a coordinate at or past its size minus one wraps.
  tpag_pkg::coord_t coord_r   [N];
  tpag_pkg::coord_t coord_nxt [N];
  logic             last_nxt;

  always_comb begin
    logic             carry;
    logic [tpag_pkg::SIZE_W-1:0] inc;
    carry = 1'b1;
    for (int j = N - 1; j >= 0; j--) begin
      coord_nxt[j] = coord_r[j];
      inc = {1'b0, coord_r[j]} + 9'd1;
      if (3'(j) < ord_r) begin
        if (carry) begin
          coord_nxt[j] = (inc >= sz_r[j]) ? '0 : inc[tpag_pkg::COORD_W-1:0];
        end
        carry = carry && (inc >= sz_r[j]);
      end
    end
    last_nxt = carry;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      for (int j = 0; j < N; j++) begin
        coord_r[j] <= '0;
      end
    end else if (in_acc) begin
      for (int j = 0; j < N; j++) begin
        coord_r[j] <= coord_nxt[j];
      end
    end
  end

  // Stage 1: one product per axis from the coordinates before the advance.
  logic [tpag_pkg::INDEX_W-1:0] s1_prod_r [N];
  logic [tpag_pkg::VALUE_W-1:0] s1_value_r;
  logic                         s1_last_r, s1_err_r;

  always_ff @(posedge clk) begin
    if (in_acc) begin
      for (int j = 0; j < N; j++) begin
        s1_prod_r[j] <= 32'(coord_r[j]) * 32'(stride_r[j]);
      end
      s1_value_r <= in_tdata;
      s1_last_r  <= last_nxt;
      s1_err_r   <= err_r;
    end
  end

  // Stage 2: sum into the output register. The sum wraps modulo 2^32.
  logic [tpag_pkg::INDEX_W-1:0] idx_sum;
  logic [tpag_pkg::INDEX_W-1:0] out_index_r;
  logic [tpag_pkg::VALUE_W-1:0] out_value_r;
  logic                         out_last_r, out_err_r;

  assign idx_sum = s1_prod_r[0] + s1_prod_r[1] + s1_prod_r[2] + s1_prod_r[3];

  always_ff @(posedge clk) begin
    if (s1_move) begin
      out_index_r <= s1_err_r ? '0 : idx_sum;
      out_value_r <= s1_value_r;
      out_last_r  <= s1_last_r;
      out_err_r   <= s1_err_r;
    end
  end

  assign out_tvalid = s2_v_r;
  assign out_tdata  = {out_value_r, out_index_r};
  assign out_tlast  = out_last_r;
  assign out_tuser  = out_err_r;

endmodule

// File: tb/sv/tpag_result_checker.sv
`timescale 1ns / 1ps
// Result checker for the tensor permute address generator: it watches the
// input, result and register-write ports, predicts every result and compares.
// Depends on tpag_pkg for widths, the register index enum and the size type.
module tpag_result_checker
  import tpag_pkg::*;
(
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_tvalid,
  input  logic        in_tready,
  input  logic [31:0] in_tdata,    // [31:0] element_value
  input  logic        out_tvalid,
  input  logic        out_tready,
  input  logic [63:0] out_tdata,   // [31:0] dest_index, [63:32] out_value
  input  logic        out_tlast,   // last_element
  input  logic        out_tuser,   // perm_error
  input  logic        cfg_we,
  input  logic [2:0]  cfg_index,
  input  logic [8:0]  cfg_wdata,
  output int          mismatch_count,
  output int          pending_results
);

  typedef struct packed {
    logic [INDEX_W-1:0] dest_index;
    logic [VALUE_W-1:0] value;
    logic               last;
    logic               perm_err;
  } placement_t;

  placement_t placements_due[$];

  // Shadow copy of the configuration and of the source coordinate odometer.
  logic [ORDER_W-1:0] order_reg;
  size_t              size_reg[MAX_ORDER];
  logic [PERM_W-1:0]  perm_reg;
  logic               use_given_reg;
  coord_t             coord[MAX_ORDER];

  function automatic logic [8:0] axis_extent(input size_t raw);
    if (raw == 9'd0) return 9'd1;
    if (raw > 9'd256) return 9'd256;
    return raw;
  endfunction

  task automatic report_mismatch(input string what);
    mismatch_count++;
    if (mismatch_count <= 50) $display("[%0t] mismatch: %s", $time, what);
  endtask

  always @(posedge clk) begin : watch
    placement_t  want;
    int          ord_eff;
    int          k;
    logic [1:0]  src_axis[MAX_ORDER];
    logic [63:0] stride[MAX_ORDER];
    logic [63:0] span;
    logic [63:0] idx;
    logic [3:0]  seen;
    logic        bad;
    logic        carry;
    logic [8:0]  next_c;

    if (!rst_n) begin
      order_reg       = '0;
      perm_reg        = PERM_RESET;
      use_given_reg   = 1'b0;
      mismatch_count  = 0;
      for (k = 0; k < MAX_ORDER; k++) begin
        size_reg[k] = 9'd1;
        coord[k]    = '0;
      end
      placements_due.delete();
    end else begin
      if (in_tvalid && in_tready) begin
        ord_eff = (order_reg > ORDER_MAX) ? int'(ORDER_MAX) : int'(order_reg);
        seen = '0;
        bad  = 1'b0;
        for (k = 0; k < MAX_ORDER; k++) begin
          src_axis[k] = '0;
          stride[k]   = '0;
        end
        for (k = 0; k < ord_eff; k++) begin
          src_axis[k] = use_given_reg ? perm_reg[2*k +: 2] : 2'(ord_eff - 1 - k);
          if (src_axis[k] >= ord_eff || seen[src_axis[k]]) bad = 1'b1;
          else seen[src_axis[k]] = 1'b1;
        end

        // Strides follow the permuted sizes, the last result axis being unit stride.
        idx = '0;
        if (!bad && ord_eff > 0) begin
          span = 64'd1;
          for (k = ord_eff - 1; k >= 0; k--) begin
            stride[src_axis[k]] = span;
            span = span * axis_extent(size_reg[src_axis[k]]);
          end
          for (k = 0; k < ord_eff; k++) idx = idx + 64'(coord[k]) * stride[k];
        end

        // Odometer step, last axis fastest; a full carry out marks the last element.
        carry = 1'b1;
        for (k = ord_eff - 1; k >= 0; k--) begin
          if (carry) begin
            next_c = {1'b0, coord[k]} + 9'd1;
            if (next_c >= axis_extent(size_reg[k])) begin
              coord[k] = '0;
            end else begin
              coord[k] = next_c[7:0];
              carry    = 1'b0;
            end
          end
        end

        want.dest_index = bad ? '0 : idx[INDEX_W-1:0];
        want.value      = in_tdata;
        want.last       = carry;
        want.perm_err   = bad;
        placements_due.push_back(want);
      end

      if (out_tvalid && out_tready) begin
        if (placements_due.size() == 0) begin
          report_mismatch($sformatf("result item with nothing expected, tdata %h", out_tdata));
        end else begin
          want = placements_due.pop_front();
          if (out_tdata[31:0] !== want.dest_index)
            report_mismatch($sformatf("dest_index %h, expected %h",
                                      out_tdata[31:0], want.dest_index));
          if (out_tdata[63:32] !== want.value)
            report_mismatch($sformatf("out_value %h, expected %h",
                                      out_tdata[63:32], want.value));
          if (out_tlast !== want.last)
            report_mismatch($sformatf("last_element %b, expected %b", out_tlast, want.last));
          if (out_tuser !== want.perm_err)
            report_mismatch($sformatf("perm_error %b, expected %b", out_tuser, want.perm_err));
        end
      end

      if (cfg_we) begin
        case (cfg_reg_t'(cfg_index))
          REG_TENSOR_ORDER: order_reg     = cfg_wdata[ORDER_W-1:0];
          REG_AXIS_SIZE_0:  size_reg[0]   = cfg_wdata;
          REG_AXIS_SIZE_1:  size_reg[1]   = cfg_wdata;
          REG_AXIS_SIZE_2:  size_reg[2]   = cfg_wdata;
          REG_AXIS_SIZE_3:  size_reg[3]   = cfg_wdata;
          REG_AXIS_PERM:    perm_reg      = cfg_wdata[PERM_W-1:0];
          REG_USE_GIVEN:    use_given_reg = cfg_wdata[0];
          default: ;
        endcase
      end
    end
    pending_results <= placements_due.size();
  end

endmodule

// File: tb/sv/tensor_permute_address_gen_tb.sv
`timescale 1ns / 1ps
// Top of the tensor permute address generator testbench: clock, reset,
// stimulus, receiver back-pressure, watchdog and verdict.
// Depends on tpag_pkg, tensor_permute_address_gen and tpag_result_checker.
module tensor_permute_address_gen_tb;
  import tpag_pkg::*;

  // Number of random items to send after the directed part.
  localparam int RANDOM_ITEMS = 1400;
  // Length of the one long receiver hold-off that fills the pipeline.
  localparam int HOLD_CYCLES  = 240;
  // Cycles without any accepted item or register write before giving up.
  localparam int STALL_LIMIT  = 3000;
  // Cycles to keep watching the result port after the last expected item.
  localparam int DRAIN_CYCLES = 8;
  // An index that names no register; writes to it must be ignored.
  localparam logic [CFG_IDX_W-1:0] REG_UNUSED = 3'd7;

  typedef enum logic [1:0] {RX_ALWAYS, RX_MOSTLY, RX_SPARSE, RX_PATTERN} rx_mode_t;

  logic        clk = 1'b0;
  logic        rst_n = 1'b0;
  logic        in_tvalid = 1'b0;
  logic        in_tready;
  logic [31:0] in_tdata = '0;
  logic        out_tvalid;
  logic        out_tready = 1'b0;
  logic [63:0] out_tdata;
  logic        out_tlast;
  logic        out_tuser;
  logic        cfg_we = 1'b0;
  logic [2:0]  cfg_index = '0;
  logic [8:0]  cfg_wdata = '0;

  int          mismatch_count;
  int          pending_results;
  int          quiet_cycles = 0;
  rx_mode_t    rx_mode = RX_ALWAYS;
  logic        hold_go = 1'b0;

  always #4 clk = ~clk;

  tensor_permute_address_gen dut (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_tvalid  (in_tvalid),
    .in_tready  (in_tready),
    .in_tdata   (in_tdata),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .out_tdata  (out_tdata),
    .out_tlast  (out_tlast),
    .out_tuser  (out_tuser),
    .cfg_we     (cfg_we),
    .cfg_index  (cfg_index),
    .cfg_wdata  (cfg_wdata)
  );

  tpag_result_checker result_checker (
    .clk             (clk),
    .rst_n           (rst_n),
    .in_tvalid       (in_tvalid),
    .in_tready       (in_tready),
    .in_tdata        (in_tdata),
    .out_tvalid      (out_tvalid),
    .out_tready      (out_tready),
    .out_tdata       (out_tdata),
    .out_tlast       (out_tlast),
    .out_tuser       (out_tuser),
    .cfg_we          (cfg_we),
    .cfg_index       (cfg_index),
    .cfg_wdata       (cfg_wdata),
    .mismatch_count  (mismatch_count),
    .pending_results (pending_results)
  );

  // Watchdog: a run that stops moving for too long is a failure. Register
  // writes count as progress, since the block stalls its input while it settles.
  always @(posedge clk) begin
    if (rst_n) begin
      if ((in_tvalid && in_tready) || (out_tvalid && out_tready) || cfg_we) begin
        quiet_cycles <= 0;
      end else begin
        quiet_cycles <= quiet_cycles + 1;
      end
      if (quiet_cycles >= STALL_LIMIT) begin
        $display("Simulation FAILED");
        $finish;
      end
    end
  end

  // Receiver. Its readiness follows the mode that the current phase picks, and
  // once in the run it holds off for a long stretch so that the output register
  // and the first stage fill and in_tready has to drop.
  initial begin : receiver
    int         pat_pos;
    logic [7:0] pattern;
    logic       hold_done;
    pattern   = 8'b1011_0110;
    pat_pos   = 0;
    hold_done = 1'b0;
    forever begin
      @(posedge clk);
      if (hold_go && !hold_done) begin
        hold_done = 1'b1;
        out_tready <= 1'b0;
        repeat (HOLD_CYCLES) @(posedge clk);
      end else begin
        case (rx_mode)
          RX_ALWAYS:  out_tready <= 1'b1;
          RX_MOSTLY:  out_tready <= ($urandom_range(0, 3) != 0);
          RX_SPARSE:  out_tready <= ($urandom_range(0, 3) == 0);
          default: begin
            out_tready <= pattern[pat_pos];
            pat_pos = (pat_pos + 1) % 8;
          end
        endcase
      end
    end
  end

  // Offer one item and return once it has been taken. The sampled in_tready is
  // the value at the edge, so a high reading means the item went in there.
  task automatic send_item(input logic [31:0] value);
    in_tvalid <= 1'b1;
    in_tdata  <= value;
    @(posedge clk);
    while (!in_tready) @(posedge clk);
  endtask

  // Send a run of random items in bursts of random length. A gap limit of zero
  // gives a stretch with the input valid on every cycle.
  task automatic send_run(input int count, input int burst_max, input int gap_max);
    int          left;
    int          burst;
    int          gap;
    logic [31:0] value;
    left = count;
    while (left > 0) begin
      burst = $urandom_range(1, burst_max);
      if (burst > left) burst = left;
      repeat (burst) begin
        case ($urandom_range(0, 7))
          0:       value = '0;
          1:       value = '1;
          default: value = $urandom;
        endcase
        send_item(value);
      end
      left -= burst;
      gap = $urandom_range(0, gap_max);
      if (gap > 0) begin
        in_tvalid <= 1'b0;
        repeat (gap) @(posedge clk);
      end
    end
    in_tvalid <= 1'b0;
  endtask

  // Registers may only change while the block is idle, i.e. once every result
  // of the items sent so far has come out. The count from the checker is
  // registered, so it does not yet show an item taken at the current edge.
  task automatic wait_for_results();
    @(posedge clk);
    while (pending_results != 0) @(posedge clk);
  endtask

  // One register write per cycle; the caller lowers the write enable after a
  // group so that it is never lowered and raised within one time step.
  task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input logic [8:0] data);
    cfg_we    <= 1'b1;
    cfg_index <= idx;
    cfg_wdata <= data;
    @(posedge clk);
  endtask

  task automatic set_tensor_shape(input logic [2:0] ord, input logic [8:0] s0,
                                  input logic [8:0] s1, input logic [8:0] s2,
                                  input logic [8:0] s3, input logic [7:0] perm,
                                  input logic use_given);
    write_reg(REG_TENSOR_ORDER, {6'd0, ord});
    write_reg(REG_AXIS_SIZE_0, s0);
    write_reg(REG_AXIS_SIZE_1, s1);
    write_reg(REG_AXIS_SIZE_2, s2);
    write_reg(REG_AXIS_SIZE_3, s3);
    write_reg(REG_AXIS_PERM, {1'b0, perm});
    write_reg(REG_USE_GIVEN, {8'd0, use_given});
    cfg_we <= 1'b0;
  endtask

  initial begin : stimulus
    int         sent;
    int         phase;
    int         count;
    int         eo;
    int         k;
    int         j;
    int         tmp;
    int         burst_max;
    int         gap_max;
    int         p[4];
    logic [2:0] ord;
    logic [8:0] sz[4];
    logic [7:0] perm;
    logic       use_given;

    repeat (4) @(posedge clk);
    rst_n <= 1'b1;

    // Directed part. Out of reset the tensor is a scalar: every element goes
    // to index 0 and is the last one.
    send_item(32'h0000_0000);
    send_item(32'hFFFF_FFFF);
    in_tvalid <= 1'b0;

    // A 3x2 matrix with the axes reversed: a plain transpose, run to the end.
    wait_for_results();
    set_tensor_shape(3'd2, 9'd3, 9'd2, 9'd1, 9'd1, 8'h00, 1'b0);
    for (k = 0; k < 6; k++) send_item(32'h1000_0000 + k);
    in_tvalid <= 1'b0;

    // Order 3 with a given permutation (result axes take source 1, 2, 0);
    // only half the tensor is sent, so the odometer is left mid-way.
    wait_for_results();
    set_tensor_shape(3'd3, 9'd2, 9'd2, 9'd2, 9'd1, 8'h09, 1'b1);
    for (k = 0; k < 4; k++) send_item(32'hA5A5_0000 + k);
    in_tvalid <= 1'b0;

    // A repeated entry in the permutation: error on every result, while the
    // odometer keeps counting to the end of the tensor.
    wait_for_results();
    set_tensor_shape(3'd3, 9'd2, 9'd2, 9'd2, 9'd1, 8'h05, 1'b1);
    for (k = 0; k < 4; k++) send_item(32'h5A5A_0000 + k);
    in_tvalid <= 1'b0;

    // Permutation entries at or above the order.
    wait_for_results();
    set_tensor_shape(3'd2, 9'd2, 9'd2, 9'd1, 9'd1, 8'h0E, 1'b1);
    send_item(32'h8000_0001);
    send_item(32'h7FFF_FFFE);
    in_tvalid <= 1'b0;

    // An order above the maximum counts as four; a zero size counts as one
    // and an oversized one as 256. The coordinate left at 1 on axis 0 is now
    // past its size and has to wrap. A write to an unused index is ignored.
    wait_for_results();
    write_reg(REG_UNUSED, 9'h1FF);
    set_tensor_shape(3'd7, 9'd0, 9'd511, 9'd256, 9'd1, 8'hFF, 1'b0);
    for (k = 0; k < 3; k++) send_item(32'hC0DE_0000 + k);
    in_tvalid <= 1'b0;

    // Every axis at the largest size with the identity permutation.
    wait_for_results();
    set_tensor_shape(3'd4, 9'd256, 9'd256, 9'd256, 9'd256, 8'hE4, 1'b1);
    for (k = 0; k < 3; k++) send_item(32'hDEAD_BEE0 + k);
    in_tvalid <= 1'b0;

    // Random part. Each phase picks a shape, an idling profile and a run
    // length. Shapes are mostly small so that tensors end and restart often,
    // and runs rarely line up with tensor ends, so the odometer is regularly
    // left mid-way when the sizes change.
    sent  = 0;
    phase = 0;
    while (sent < RANDOM_ITEMS) begin
      wait_for_results();

      case ($urandom_range(0, 9))
        0:       ord = 3'd0;
        1:       ord = 3'($urandom_range(5, 7));
        default: ord = 3'($urandom_range(1, 4));
      endcase
      eo = (ord > ORDER_MAX) ? int'(ORDER_MAX) : int'(ord);

      for (k = 0; k < 4; k++) begin
        if ($urandom_range(0, 9) == 0) sz[k] = 9'($urandom_range(0, 511));
        else sz[k] = 9'($urandom_range(1, 5));
      end

      // Mostly a valid permutation of the axes in use, with random bits above
      // the order; otherwise an arbitrary byte, often invalid.
      use_given = 1'($urandom_range(0, 1));
      perm = 8'($urandom_range(0, 255));
      if ($urandom_range(0, 3) != 0) begin
        for (k = 0; k < 4; k++) p[k] = k;
        for (k = eo - 1; k > 0; k--) begin
          j = $urandom_range(0, k);
          tmp = p[k];
          p[k] = p[j];
          p[j] = tmp;
        end
        for (k = 0; k < eo; k++) perm[2*k +: 2] = p[k][1:0];
      end

      count = $urandom_range(8, 60);
      // Now and then the fastest axis gets the full 256 so that a coordinate
      // runs through all its values.
      if (eo > 0 && $urandom_range(0, 7) == 0) begin
        sz[eo-1] = 9'd256;
        count = $urandom_range(256, 300);
      end

      set_tensor_shape(ord, sz[0], sz[1], sz[2], sz[3], perm, use_given);

      rx_mode   = rx_mode_t'($urandom_range(0, 3));
      burst_max = $urandom_range(1, 16);
      gap_max   = $urandom_range(0, 6);

      // One phase keeps the sender busy while the receiver holds off.
      if (phase == 3) begin
        count     = 80;
        gap_max   = 0;
        burst_max = 16;
        hold_go   = 1'b1;
      end

      send_run(count, burst_max, gap_max);
      sent += count;
      phase++;
    end

    // Let the last results out, then keep watching for stray ones.
    wait_for_results();
    repeat (DRAIN_CYCLES) @(posedge clk);
    if (mismatch_count == 0) begin
      $display("Simulation PASSED");
    end else begin
      $display("Simulation FAILED");
    end
    $finish;
  end

endmodule
